// ===== src/satq_pkg.sv =====
// satq_pkg: shared constants, control word layout and microcode rom for the
// summed-area table query block. no dependencies.

package satq_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int FIELD_W   = 6;
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 45;
    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W    = 4;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    // memory address sources
    localparam logic [2:0] ADDR_ABOVE = 3'd0;
    localparam logic [2:0] ADDR_LOAD  = 3'd1;
    localparam logic [2:0] ADDR_BR    = 3'd2;
    localparam logic [2:0] ADDR_TR    = 3'd3;
    localparam logic [2:0] ADDR_BL    = 3'd4;
    localparam logic [2:0] ADDR_TL    = 3'd5;

    // accumulator operations
    localparam logic [2:0] ACC_HOLD  = 3'd0;
    localparam logic [2:0] ACC_CLEAR = 3'd1;
    localparam logic [2:0] ACC_LOAD  = 3'd2;
    localparam logic [2:0] ACC_ADD   = 3'd3;
    localparam logic [2:0] ACC_SUB   = 3'd4;
    localparam logic [2:0] ACC_ROW   = 3'd5;

    // read data gating: entries left of or above the table read as zero
    localparam logic [2:0] GATE_ONE = 3'd0;
    localparam logic [2:0] GATE_ROW = 3'd1;
    localparam logic [2:0] GATE_T   = 3'd2;
    localparam logic [2:0] GATE_L   = 3'd3;
    localparam logic [2:0] GATE_TL  = 3'd4;

    localparam logic [1:0] JMP_NONE   = 2'd0;
    localparam logic [1:0] JMP_ALWAYS = 2'd1;
    localparam logic [1:0] JMP_CMD    = 2'd2;
    localparam logic [1:0] JMP_BAD    = 2'd3;

    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_L0   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_L1   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_L2   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_Q0   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_Q1   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_Q2   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_Q3   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_Q4   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_EMIT = 4'd9;

    typedef struct packed {
        logic              wait_in;
        logic              mem_rd;
        logic              mem_wr;
        logic [2:0]        addr_sel;
        logic [2:0]        acc_op;
        logic [2:0]        gate;
        logic              rrs_add;
        logic              load_adv;
        logic              emit;
        logic [1:0]        jmp;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        ctrl_t word;
        logic  fire;
    } seq_ctl_t;

    typedef struct packed {
        logic bad;
        logic out_stall;
    } dp_status_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '0;
        case (step)
            STEP_IDLE:
            begin
                w.wait_in = 1'b1;
                w.jmp     = JMP_CMD;
                w.target  = STEP_Q0;
            end
            STEP_L0:
            begin
                w.mem_rd   = 1'b1;
                w.addr_sel = ADDR_ABOVE;
                w.rrs_add  = 1'b1;
            end
            STEP_L1:
            begin
                w.acc_op = ACC_ROW;
                w.gate   = GATE_ROW;
            end
            STEP_L2:
            begin
                w.mem_wr   = 1'b1;
                w.addr_sel = ADDR_LOAD;
                w.emit     = 1'b1;
                w.load_adv = 1'b1;
                w.jmp      = JMP_ALWAYS;
                w.target   = STEP_IDLE;
            end
            STEP_Q0:
            begin
                w.mem_rd   = 1'b1;
                w.addr_sel = ADDR_BR;
                w.acc_op   = ACC_CLEAR;
                w.jmp      = JMP_BAD;
                w.target   = STEP_EMIT;
            end
            STEP_Q1:
            begin
                w.mem_rd   = 1'b1;
                w.addr_sel = ADDR_TR;
                w.acc_op   = ACC_LOAD;
                w.gate     = GATE_ONE;
            end
            STEP_Q2:
            begin
                w.mem_rd   = 1'b1;
                w.addr_sel = ADDR_BL;
                w.acc_op   = ACC_SUB;
                w.gate     = GATE_T;
            end
            STEP_Q3:
            begin
                w.mem_rd   = 1'b1;
                w.addr_sel = ADDR_TL;
                w.acc_op   = ACC_SUB;
                w.gate     = GATE_L;
            end
            STEP_Q4:
            begin
                w.acc_op = ACC_ADD;
                w.gate   = GATE_TL;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.jmp    = JMP_ALWAYS;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.jmp    = JMP_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // a size of zero acts as one, a size above the limit acts as the limit
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                   input int limit);
        logic [SIZE_W-1:0] res;
        if (r == '0)
            res = SIZE_W'(1);
        else if (32'(r) > limit)
            res = SIZE_W'(limit);
        else
            res = r;
        return res;
    endfunction

endpackage

// ===== src/satq_if.sv =====
// satq_req_if / satq_rsp_if: valid/ready channels for request and result words.
// depends on satq_pkg for field widths.

interface satq_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [satq_pkg::VAL_W-1:0]    value;
    logic [satq_pkg::FIELD_W-1:0]  row_top;
    logic [satq_pkg::FIELD_W-1:0]  col_left;
    logic [satq_pkg::FIELD_W-1:0]  row_bottom;
    logic [satq_pkg::FIELD_W-1:0]  col_right;

    modport source (output valid, cmd, value, row_top, col_left, row_bottom, col_right,
                    input ready);
    modport sink   (input valid, cmd, value, row_top, col_left, row_bottom, col_right,
                    output ready);
endinterface

interface satq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [satq_pkg::SUM_W-1:0]  sum;
    logic                        last_of_matrix;
    logic                        error;

    modport source (output valid, kind, sum, last_of_matrix, error, input ready);
    modport sink   (input valid, kind, sum, last_of_matrix, error, output ready);
endinterface

// ===== src/satq_seq.sv =====
// satq_seq: step counter and microcode rom, issues one control word per cycle while no step holds.
// depends on satq_pkg.

module satq_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_cmd,
    input  satq_pkg::dp_status_t status,
    output satq_pkg::seq_ctl_t   ctl
);

    logic [satq_pkg::STEP_W-1:0] step_reg;
    logic [satq_pkg::STEP_W-1:0] step_next;
    satq_pkg::ctrl_t             word;
    logic                        fire;

    assign word = satq_pkg::ucode(step_reg);

    // a step holds while waiting for a word or for the output register to drain
    assign fire = (!word.wait_in || in_valid) && !(word.emit && status.out_stall);

    assign ctl.word = word;
    assign ctl.fire = fire;

    always_comb
    begin
        step_next = step_reg;
        if (fire)
        begin
            case (word.jmp)
                satq_pkg::JMP_NONE:   step_next = step_reg + 1'b1;
                satq_pkg::JMP_ALWAYS: step_next = word.target;
                satq_pkg::JMP_CMD:
                    step_next = (in_cmd == satq_pkg::CMD_QUERY) ? word.target
                                                                : step_reg + 1'b1;
                satq_pkg::JMP_BAD:
                    step_next = status.bad ? word.target : step_reg + 1'b1;
                default:              step_next = satq_pkg::STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= satq_pkg::STEP_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

// ===== src/satq_dp.sv =====
// satq_dp: prefix table memory, load position, accumulator and result register.
// depends on satq_pkg, satq_if and control words from satq_seq.

module satq_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [satq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [satq_pkg::SIZE_W-1:0]      cfg_data,
    input  satq_pkg::seq_ctl_t               ctl,
    output satq_pkg::dp_status_t             status,
    satq_req_if.sink                         req,
    satq_rsp_if.source                       rsp
);

    localparam int SUM_W  = satq_pkg::SUM_W;
    localparam int ROW_W  = satq_pkg::ROW_W;
    localparam int COL_W  = satq_pkg::COL_W;
    localparam int SIZE_W = satq_pkg::SIZE_W;

    logic [SUM_W-1:0] mem [satq_pkg::DEPTH];

    // latched request
    logic                       cmd_reg;
    logic [satq_pkg::VAL_W-1:0] value_reg;
    logic [ROW_W-1:0]           t_reg;
    logic [COL_W-1:0]           l_reg;
    logic [ROW_W-1:0]           b_reg;
    logic [COL_W-1:0]           r_reg;
    logic                       bad_reg;

    // load state
    logic [SIZE_W-1:0] rows_reg;
    logic [SIZE_W-1:0] cols_reg;
    logic [ROW_W-1:0]  load_row_reg;
    logic [COL_W-1:0]  load_col_reg;
    logic [SUM_W-1:0]  rrs_reg;
    logic              complete_reg;

    logic [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  rdata_reg;

    logic              rsp_valid_reg;
    logic              rsp_kind_reg;
    logic [SUM_W-1:0]  rsp_sum_reg;
    logic              rsp_last_reg;
    logic              rsp_error_reg;

    logic [SIZE_W-1:0]           rows_eff;
    logic [SIZE_W-1:0]           cols_eff;
    logic                        accept;
    logic                        bad_now;
    logic                        pos_out;
    logic                        col_end;
    logic                        row_end;
    logic                        gate_on;
    logic [SUM_W-1:0]            gated;
    logic [satq_pkg::ADDR_W-1:0] addr;
    logic                        do_emit;

    assign rows_eff = satq_pkg::eff_size(rows_reg, satq_pkg::MAX_ROWS);
    assign cols_eff = satq_pkg::eff_size(cols_reg, satq_pkg::MAX_COLS);

    assign req.ready = ctl.word.wait_in;
    assign accept    = ctl.fire && ctl.word.wait_in;

    assign bad_now = !complete_reg
                  || (req.row_top > req.row_bottom)
                  || (req.col_left > req.col_right)
                  || (SIZE_W'(req.row_bottom) >= rows_eff)
                  || (SIZE_W'(req.col_right) >= cols_eff);

    assign pos_out = (SIZE_W'(load_row_reg) >= rows_eff) || (SIZE_W'(load_col_reg) >= cols_eff);
    assign col_end = (SIZE_W'(load_col_reg) + SIZE_W'(1)) >= cols_eff;
    assign row_end = (SIZE_W'(load_row_reg) + SIZE_W'(1)) >= rows_eff;

    assign status.bad       = bad_reg;
    assign status.out_stall = rsp_valid_reg && !rsp.ready;

    always_comb
    begin
        case (ctl.word.addr_sel)
            satq_pkg::ADDR_ABOVE: addr = {load_row_reg - 1'b1, load_col_reg};
            satq_pkg::ADDR_LOAD:  addr = {load_row_reg, load_col_reg};
            satq_pkg::ADDR_BR:    addr = {b_reg, r_reg};
            satq_pkg::ADDR_TR:    addr = {t_reg - 1'b1, r_reg};
            satq_pkg::ADDR_BL:    addr = {b_reg, l_reg - 1'b1};
            satq_pkg::ADDR_TL:    addr = {t_reg - 1'b1, l_reg - 1'b1};
            default:              addr = {load_row_reg, load_col_reg};
        endcase
    end

    always_comb
    begin
        case (ctl.word.gate)
            satq_pkg::GATE_ONE: gate_on = 1'b1;
            satq_pkg::GATE_ROW: gate_on = (load_row_reg != '0);
            satq_pkg::GATE_T:   gate_on = (t_reg != '0);
            satq_pkg::GATE_L:   gate_on = (l_reg != '0);
            satq_pkg::GATE_TL:  gate_on = (t_reg != '0) && (l_reg != '0);
            default:            gate_on = 1'b0;
        endcase
    end

    assign gated = gate_on ? rdata_reg : '0;

    // single port table
    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            if (ctl.word.mem_wr)
                mem[addr] <= acc_reg;
            if (ctl.word.mem_rd)
                rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= req.value;
            t_reg     <= ROW_W'(req.row_top);
            l_reg     <= COL_W'(req.col_left);
            b_reg     <= ROW_W'(req.row_bottom);
            r_reg     <= COL_W'(req.col_right);
        end
        if (ctl.fire)
        begin
            case (ctl.word.acc_op)
                satq_pkg::ACC_HOLD:  acc_reg <= acc_reg;
                satq_pkg::ACC_CLEAR: acc_reg <= '0;
                satq_pkg::ACC_LOAD:  acc_reg <= gated;
                satq_pkg::ACC_ADD:   acc_reg <= acc_reg + gated;
                satq_pkg::ACC_SUB:   acc_reg <= acc_reg - gated;
                satq_pkg::ACC_ROW:   acc_reg <= rrs_reg + gated;
                default:             acc_reg <= acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= satq_pkg::CMD_LOAD;
            bad_reg <= 1'b0;
        end
        else if (accept)
        begin
            cmd_reg <= req.cmd;
            bad_reg <= (req.cmd == satq_pkg::CMD_QUERY) && bad_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= SIZE_W'(satq_pkg::MAX_ROWS);
            cols_reg     <= SIZE_W'(satq_pkg::MAX_COLS);
            load_row_reg <= '0;
            load_col_reg <= '0;
            rrs_reg      <= '0;
            complete_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == satq_pkg::REG_ROWS)
                rows_reg <= cfg_data;
            else
                cols_reg <= cfg_data;
            load_row_reg <= '0;
            load_col_reg <= '0;
            rrs_reg      <= '0;
            complete_reg <= 1'b0;
        end
        else if (ctl.fire)
        begin
            // a load after a finished table, or past a shrunk size, restarts
            if (accept && req.cmd == satq_pkg::CMD_LOAD)
            begin
                if (complete_reg || pos_out)
                begin
                    load_row_reg <= '0;
                    load_col_reg <= '0;
                    rrs_reg      <= '0;
                end
                complete_reg <= 1'b0;
            end
            if (ctl.word.rrs_add)
                rrs_reg <= rrs_reg
                         + {{(SUM_W-satq_pkg::VAL_W){value_reg[satq_pkg::VAL_W-1]}}, value_reg};
            if (ctl.word.load_adv)
            begin
                if (col_end)
                begin
                    load_col_reg <= '0;
                    rrs_reg      <= '0;
                    if (row_end)
                    begin
                        load_row_reg <= '0;
                        complete_reg <= 1'b1;
                    end
                    else
                        load_row_reg <= load_row_reg + 1'b1;
                end
                else
                    load_col_reg <= load_col_reg + 1'b1;
            end
        end
    end

    assign do_emit = ctl.fire && ctl.word.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (do_emit)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            rsp_kind_reg  <= cmd_reg;
            rsp_sum_reg   <= acc_reg;
            rsp_last_reg  <= (cmd_reg == satq_pkg::CMD_LOAD) && col_end && row_end;
            rsp_error_reg <= bad_reg;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.kind           = rsp_kind_reg;
    assign rsp.sum            = rsp_sum_reg;
    assign rsp.last_of_matrix = rsp_last_reg;
    assign rsp.error          = rsp_error_reg;

endmodule

// ===== src/summed_area_table_query_core.sv =====
// summed_area_table_query_core: top level, sequencer plus datapath.
// depends on satq_pkg, satq_if, satq_seq and satq_dp.
//
// usage:
//   req carries one word per item: cmd 0 loads the next matrix element in
//   raster order, cmd 1 asks for the sum of an inclusive rectangle. rsp gives
//   exactly one word per request: a load returns its prefix sum (last_of_matrix
//   set on the load that fills the table), a query returns the rectangle sum or
//   error with sum 0. the cfg port writes rows_in_use (index 0) and
//   cols_in_use (index 1); a write restarts loading at the first position and
//   must only happen while no word is in flight.
// timing:
//   the sequencer steps through a microcode program and takes one request at a
//   time. a load steps through accept, read above, add and write; a query through
//   accept, four reads from the single-port table, final add and result; a
//   rejected query through accept, first read and result. the result word is
//   registered and shows on rsp in the cycle after its last step. the single
//   table port puts each read of a query in a step of its own.
// reset: clears load position, running sum and table-complete flag and sets both sizes to 64;
//   table contents are not cleared and need no clearing. stall: a result waits in the output
//   register while the next request is already taken; apart from waiting for a request, the
//   sequencer only holds when a second result is ready before the first has been taken.

module summed_area_table_query_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [satq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [satq_pkg::SIZE_W-1:0]    cfg_data,
    satq_req_if.sink                       req,
    satq_rsp_if.source                     rsp
);

    satq_pkg::seq_ctl_t   ctl;
    satq_pkg::dp_status_t status;

    satq_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.cmd),
        .status   (status),
        .ctl      (ctl)
    );

    satq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .status    (status),
        .req       (req),
        .rsp       (rsp)
    );

endmodule

// ===== src/satq_checker.sv =====
// satq_checker: port-level assertions for summed_area_table_query_core,
// attached by bind. depends on satq_pkg for widths.

module satq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       rsp_kind,
    input logic [satq_pkg::SUM_W-1:0] rsp_sum,
    input logic                       rsp_last,
    input logic                       rsp_error
);

    // one request at a time: ready drops after a word is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one still in work");

    a_error_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_error |-> rsp_kind && rsp_sum == '0)
        else $error("rejected query with nonzero sum or load kind");

    a_last_only_load: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_last |-> !rsp_kind && !rsp_error)
        else $error("last_of_matrix on a query result");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum))
        else $error("result word changed while stalled");

endmodule

bind summed_area_table_query_core satq_checker u_satq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_kind  (rsp.kind),
    .rsp_sum   (rsp.sum),
    .rsp_last  (rsp.last_of_matrix),
    .rsp_error (rsp.error)
);

// ===== verif/tb_summed_area_table_query_core.sv =====
// testbench for summed_area_table_query_core: drives load and query words, predicts
// each prefix or rectangle sum in a local copy of the table and checks every result.
// depends on satq_pkg, satq_if and the core itself.
`timescale 1ns / 100ps

module tb_summed_area_table_query_core;

    localparam int SUM_W     = satq_pkg::SUM_W;
    localparam int VAL_W     = satq_pkg::VAL_W;
    localparam int SIZE_W    = satq_pkg::SIZE_W;
    localparam int FIELD_W   = satq_pkg::FIELD_W;
    localparam int CFG_IDX_W = satq_pkg::CFG_IDX_W;
    localparam int MAX_ROWS  = satq_pkg::MAX_ROWS;
    localparam int MAX_COLS  = satq_pkg::MAX_COLS;

    localparam logic KIND_PREFIX = 1'b0;
    localparam logic KIND_RECT   = 1'b1;
    localparam int   HOLD_CYCLES = 300;

    typedef struct packed {
        logic             kind;
        logic [SUM_W-1:0] sum;
        logic             last;
        logic             err;
    } outcome_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [SIZE_W-1:0]    cfg_val;
        logic                 cmd;
        logic [VAL_W-1:0]     value;
        logic [FIELD_W-1:0]   row_top;
        logic [FIELD_W-1:0]   col_left;
        logic [FIELD_W-1:0]   row_bottom;
        logic [FIELD_W-1:0]   col_right;
        logic                 typed;
        outcome_t             want;
    } step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    satq_req_if req_ch();
    satq_rsp_if rsp_ch();

    summed_area_table_query_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // local copy of the integral image and load position
    logic [SUM_W-1:0]  sat_mem [0:MAX_ROWS*MAX_COLS-1];
    logic [SUM_W-1:0]  row_acc;
    int unsigned       ld_row;
    int unsigned       ld_col;
    bit                tbl_done;
    logic [SIZE_W-1:0] rows_cfg;
    logic [SIZE_W-1:0] cols_cfg;

    outcome_t sums_owed [$];
    step_t    script [$];

    int items_sent;
    int results_seen;
    int queries_sent;
    int queries_rejected;
    int reg_writes;
    int fail_count;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic int unsigned size_of(input logic [SIZE_W-1:0] r,
                                            input int unsigned lim);
        if (r == '0)
            return 1;
        if (r > lim)
            return lim;
        return 32'(r);
    endfunction

    // entry at one-based (r1, c1), zero on the top or left border
    function automatic logic [SUM_W-1:0] sat_at(input int unsigned r1, input int unsigned c1);
        if (r1 == 0 || c1 == 0)
            return '0;
        return sat_mem[(r1 - 1) * MAX_COLS + (c1 - 1)];
    endfunction

    function automatic void restart_pass();
        row_acc  = '0;
        ld_row   = 0;
        ld_col   = 0;
        tbl_done = 1'b0;
    endfunction

    function automatic outcome_t sat_update(input step_t s);
        outcome_t         o;
        int unsigned      nr;
        int unsigned      nc;
        int unsigned      t;
        int unsigned      l;
        int unsigned      b;
        int unsigned      r;
        logic [SUM_W-1:0] v;
        logic [SUM_W-1:0] p;
        o  = '0;
        nr = size_of(rows_cfg, MAX_ROWS);
        nc = size_of(cols_cfg, MAX_COLS);
        if (s.cmd == satq_pkg::CMD_LOAD)
        begin
            if (tbl_done)
                restart_pass();
            if (ld_row >= nr || ld_col >= nc)
            begin
                ld_row  = 0;
                ld_col  = 0;
                row_acc = '0;
            end
            v       = {{(SUM_W-VAL_W){s.value[VAL_W-1]}}, s.value};
            row_acc = row_acc + v;
            p       = row_acc + sat_at(ld_row, ld_col + 1);
            sat_mem[ld_row * MAX_COLS + ld_col] = p;
            if (ld_col + 1 >= nc)
            begin
                ld_col  = 0;
                row_acc = '0;
                if (ld_row + 1 >= nr)
                begin
                    ld_row   = 0;
                    tbl_done = 1'b1;
                    o.last   = 1'b1;
                end
                else
                    ld_row++;
            end
            else
                ld_col++;
            o.kind = KIND_PREFIX;
            o.sum  = p;
        end
        else
        begin
            t = 32'(s.row_top);
            l = 32'(s.col_left);
            b = 32'(s.row_bottom);
            r = 32'(s.col_right);
            o.kind = KIND_RECT;
            o.err  = !tbl_done || t > b || l > r || b >= nr || r >= nc;
            if (!o.err)
                o.sum = sat_at(b + 1, r + 1) - sat_at(t, r + 1) - sat_at(b + 1, l)
                      + sat_at(t, l);
        end
        return o;
    endfunction

    function automatic step_t ld(input logic [VAL_W-1:0] v);
        step_t s;
        s       = '0;
        s.cmd   = satq_pkg::CMD_LOAD;
        s.value = v;
        return s;
    endfunction

    function automatic step_t qry(input logic [FIELD_W-1:0] t, input logic [FIELD_W-1:0] l,
                                  input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] r);
        step_t s;
        s            = '0;
        s.cmd        = satq_pkg::CMD_QUERY;
        s.value      = $urandom;
        s.row_top    = t;
        s.col_left   = l;
        s.row_bottom = b;
        s.col_right  = r;
        return s;
    endfunction

    function automatic step_t wr(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] d);
        step_t s;
        s         = '0;
        s.is_cfg  = 1'b1;
        s.cfg_idx = idx;
        s.cfg_val = d;
        return s;
    endfunction

    function automatic step_t known(input step_t s, input logic [SUM_W-1:0] sum,
                                    input logic last, input logic err);
        step_t k;
        k           = s;
        k.typed     = 1'b1;
        k.want.kind = (s.cmd == satq_pkg::CMD_QUERY) ? KIND_RECT : KIND_PREFIX;
        k.want.sum  = sum;
        k.want.last = last;
        k.want.err  = err;
        return k;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 32'h7FFF_FFFF;
        if (k == 1)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    // mostly rectangles inside the table, the rest any corners at all
    function automatic step_t rand_query(input int unsigned nr, input int unsigned nc);
        int unsigned t;
        int unsigned l;
        if ($urandom_range(0, 3) == 0)
            return qry(FIELD_W'($urandom), FIELD_W'($urandom),
                       FIELD_W'($urandom), FIELD_W'($urandom));
        t = $urandom_range(0, nr - 1);
        l = $urandom_range(0, nc - 1);
        return qry(FIELD_W'(t), FIELD_W'(l),
                   FIELD_W'($urandom_range(t, nr - 1)), FIELD_W'($urandom_range(l, nc - 1)));
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        if (k < 88)
            return $urandom_range(1, 3);
        if (k < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    task automatic drive_word(input step_t s);
        int       gap;
        outcome_t o;
        // every fifth stretch of 40 words goes back to back
        gap = ((items_sent / 40) % 5 == 4) ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= s.cmd;
        req_ch.value      <= s.value;
        req_ch.row_top    <= s.row_top;
        req_ch.col_left   <= s.col_left;
        req_ch.row_bottom <= s.row_bottom;
        req_ch.col_right  <= s.col_right;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        o = sat_update(s);
        sums_owed.push_back(s.typed ? s.want : o);
        items_sent++;
        if (s.cmd == satq_pkg::CMD_QUERY)
        begin
            queries_sent++;
            if (o.err)
                queries_rejected++;
        end
    endtask

    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sums_owed.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == satq_pkg::REG_ROWS)
            rows_cfg = d;
        else
            cols_cfg = d;
        restart_pass();
        reg_writes++;
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] rows_w, input logic [SIZE_W-1:0] cols_w);
        int unsigned nr;
        int unsigned nc;
        int unsigned n;
        settle();
        write_size(satq_pkg::REG_ROWS, rows_w);
        write_size(satq_pkg::REG_COLS, cols_w);
        nr = size_of(rows_w, MAX_ROWS);
        nc = size_of(cols_w, MAX_COLS);
        n  = nr * nc;
        for (int unsigned k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                drive_word(rand_query(nr, nc));
            drive_word(ld(rand_value()));
        end
        repeat ($urandom_range(8, 20)) drive_word(rand_query(nr, nc));
        // sometimes start the next table over the finished one
        if ($urandom_range(0, 2) == 0)
        begin
            repeat ($urandom_range(1, n)) drive_word(ld(rand_value()));
            repeat (3) drive_word(rand_query(nr, nc));
        end
    endtask

    always @(posedge clk)
    begin : rsp_check
        outcome_t want;
        outcome_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            got.kind = rsp_ch.kind;
            got.sum  = rsp_ch.sum;
            got.last = rsp_ch.last_of_matrix;
            got.err  = rsp_ch.error;
            if (sums_owed.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: result word with nothing owed: %s %0d sum %0h last %0d err %0d",
                             $realtime, "kind", got.kind, got.sum, got.last, got.err);
                fail_count++;
            end
            else
            begin
                want = sums_owed.pop_front();
                if (got !== want)
                begin
                    if (fail_count < 10)
                    begin
                        $display("%0t: result %0d want kind %0d sum %0h last %0d err %0d,",
                                 $realtime, results_seen, want.kind, want.sum, want.last,
                                 want.err);
                        $display("    got kind %0d sum %0h last %0d err %0d",
                                 got.kind, got.sum, got.last, got.err);
                    end
                    fail_count++;
                end
            end
        end
    end

    // result side: random stalls, quiet stretches and one long hold-off
    initial
    begin
        int stall;
        int cyc;
        bit held;
        stall = 0;
        cyc   = 0;
        held  = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (!held && results_seen >= 200)
            begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else if ((cyc / 128) % 5 == 1 || $urandom_range(0, 3) != 0)
                rsp_ch.ready <= 1'b1;
            else
            begin
                rsp_ch.ready <= 1'b0;
                stall = pick_gap();
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = satq_pkg::REG_ROWS;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = satq_pkg::CMD_LOAD;
        req_ch.value      = '0;
        req_ch.row_top    = '0;
        req_ch.col_left   = '0;
        req_ch.row_bottom = '0;
        req_ch.col_right  = '0;
        items_sent        = 0;
        results_seen      = 0;
        queries_sent      = 0;
        queries_rejected  = 0;
        reg_writes        = 0;
        fail_count        = 0;
        for (int i = 0; i < MAX_ROWS * MAX_COLS; i++)
            sat_mem[i] = '0;
        rows_cfg = 7'd64;
        cols_cfg = 7'd64;
        restart_pass();

        // default 64 x 64: nothing complete yet
        script.push_back(known(qry(6'd0, 6'd0, 6'd0, 6'd0), '0, 1'b0, 1'b1));
        script.push_back(known(ld(32'd5), 45'd5, 1'b0, 1'b0));
        script.push_back(known(qry(6'd0, 6'd0, 6'd0, 6'd0), '0, 1'b0, 1'b1));
        // 1 x 1 table, extreme elements, reload over a complete table
        script.push_back(wr(satq_pkg::REG_ROWS, 7'd1));
        script.push_back(wr(satq_pkg::REG_COLS, 7'd1));
        script.push_back(known(ld(32'h7FFF_FFFF), 45'd2147483647, 1'b1, 1'b0));
        script.push_back(known(qry(6'd0, 6'd0, 6'd0, 6'd0), 45'd2147483647, 1'b0, 1'b0));
        script.push_back(known(qry(6'd0, 6'd0, 6'd0, 6'd1), '0, 1'b0, 1'b1));
        script.push_back(known(ld(32'h8000_0000), 45'h1FFF_8000_0000, 1'b1, 1'b0));
        script.push_back(known(qry(6'd0, 6'd0, 6'd0, 6'd0), 45'h1FFF_8000_0000, 1'b0, 1'b0));
        // 2 x 2 table of 1 2 / 3 4
        script.push_back(wr(satq_pkg::REG_ROWS, 7'd2));
        script.push_back(wr(satq_pkg::REG_COLS, 7'd2));
        script.push_back(known(ld(32'd1), 45'd1, 1'b0, 1'b0));
        script.push_back(known(ld(32'd2), 45'd3, 1'b0, 1'b0));
        script.push_back(known(ld(32'd3), 45'd4, 1'b0, 1'b0));
        script.push_back(known(ld(32'd4), 45'd10, 1'b1, 1'b0));
        script.push_back(known(qry(6'd0, 6'd0, 6'd1, 6'd1), 45'd10, 1'b0, 1'b0));
        script.push_back(qry(6'd1, 6'd1, 6'd1, 6'd1));
        script.push_back(qry(6'd0, 6'd1, 6'd1, 6'd1));
        script.push_back(qry(6'd1, 6'd0, 6'd1, 6'd1));
        // inverted corners and corners past the size
        script.push_back(known(qry(6'd1, 6'd0, 6'd0, 6'd1), '0, 1'b0, 1'b1));
        script.push_back(known(qry(6'd0, 6'd1, 6'd1, 6'd0), '0, 1'b0, 1'b1));
        script.push_back(known(qry(6'd63, 6'd63, 6'd63, 6'd63), '0, 1'b0, 1'b1));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                settle();
                write_size(script[i].cfg_idx, script[i].cfg_val);
            end
            else
                drive_word(script[i]);
        end

        // out-of-range sizes and the one-row and one-column extremes
        run_phase(7'd0, 7'd127);
        run_phase(7'd127, 7'd0);
        run_phase(7'd64, 7'd1);
        run_phase(7'd1, 7'd64);
        while (items_sent < 580)
            run_phase(SIZE_W'($urandom_range(1, 8)), SIZE_W'($urandom_range(1, 8)));

        settle();
        if (sums_owed.size() != 0)
            fail_count++;
        $display("sent %0d words (%0d queries, %0d rejected) over %0d size writes",
                 items_sent, queries_sent, queries_rejected, reg_writes);
        $display("checked %0d result words, %0d failures", results_seen, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/satq_pkg.sv
src/satq_if.sv
src/satq_seq.sv
src/satq_dp.sv
src/summed_area_table_query_core.sv
src/satq_checker.sv
verif/tb_summed_area_table_query_core.sv
